// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types and codes of the periodic priority task scheduler
// Command, status and task mode codes, field widths, task table entry type.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int DEF_MAX_TASKS    = 8;
   localparam int DEF_MAX_PRIORITY = 15;

   localparam int CMD_W    = 3;
   localparam int ID_W     = 6;
   localparam int PERIOD_W = 32;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 3;
   localparam int MODE_W   = 2;

   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SUSPEND  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESUME   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SUSPENDED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RESUMED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_TASK   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;
   localparam logic [STATUS_W-1:0] ST_BAD_PRIO  = 3'd7;

   localparam logic [MODE_W-1:0] MODE_READY     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BLOCKED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUSPENDED = 2'd3;

   typedef struct packed {
      logic                valid;
      logic [MODE_W-1:0]   mode;
      logic [PERIOD_W-1:0] count;
      logic [PERIOD_W-1:0] period;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] count_inc;
      logic                due;
      logic                better;
   } unit_out_type;

endpackage

// File: src/pps_if.sv
// ----------------------------------------------------------------------------
// pps_req_if / pps_rsp_if: request and response channels
// Valid/ready handshake; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pps_req_if;
   import pps_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [ID_W-1:0]     task_id;
   logic [PERIOD_W-1:0] period;
   logic [PRIO_W-1:0]   priority_req;

   modport source (output valid, cmd, task_id, period, priority_req, input ready);
   modport sink   (input valid, cmd, task_id, period, priority_req, output ready);
endinterface

interface pps_rsp_if;
   import pps_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     granted_id;

   modport source (output valid, status, granted_id, input ready);
   modport sink   (input valid, status, granted_id, output ready);
endinterface

// File: src/pps_unit.sv
// ----------------------------------------------------------------------------
// pps_unit: shared slot arithmetic
// Saturating counter increment, due compare and priority compare for the
// slot currently addressed by the sequencer.
// ----------------------------------------------------------------------------
module pps_unit (
   input  logic [pps_pkg::PERIOD_W-1:0] count,
   input  logic [pps_pkg::PERIOD_W-1:0] period,
   input  logic [pps_pkg::PRIO_W-1:0]   prio,
   input  logic [pps_pkg::PRIO_W-1:0]   best_prio,
   output pps_pkg::unit_out_type        result
);
   import pps_pkg::*;

   always_comb begin
      result.count_inc = (count == '1) ? count : count + PERIOD_W'(1);
      result.due       = (count >= period);
      result.better    = (prio < best_prio);
   end

endmodule

// File: src/pps_table.sv
// ----------------------------------------------------------------------------
// pps_table: task slot table
// One read port and one write port at sequencer-chosen slots; valid bits
// cleared by reset, other fields hold garbage until written.
// ----------------------------------------------------------------------------
module pps_table #(
   parameter int MAX_TASKS = pps_pkg::DEF_MAX_TASKS,
   parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     rd_idx,
   output pps_pkg::entry_type   rd_entry,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_idx,
   input  pps_pkg::entry_type   wr_entry,
   output logic [MAX_TASKS-1:0] valid_bits
);
   import pps_pkg::*;

   logic [MAX_TASKS-1:0]  valid_ff;
   logic [MODE_W-1:0]     mode_ff   [MAX_TASKS];
   logic [PERIOD_W-1:0]   count_ff  [MAX_TASKS];
   logic [PERIOD_W-1:0]   period_ff [MAX_TASKS];
   logic [PRIO_W-1:0]     prio_ff   [MAX_TASKS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mode_ff[wr_idx]   <= wr_entry.mode;
         count_ff[wr_idx]  <= wr_entry.count;
         period_ff[wr_idx] <= wr_entry.period;
         prio_ff[wr_idx]   <= wr_entry.prio;
      end
   end

   always_comb begin
      rd_entry.valid  = valid_ff[rd_idx];
      rd_entry.mode   = mode_ff[rd_idx];
      rd_entry.count  = count_ff[rd_idx];
      rd_entry.period = period_ff[rd_idx];
      rd_entry.prio   = prio_ff[rd_idx];
   end

   assign valid_bits = valid_ff;

endmodule

// File: src/periodic_priority_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler_core: fixed-priority periodic task table
// One request carries one command and returns exactly one response. The
// sequencer walks the task table one slot per cycle through a single read
// and write port and one shared increment/compare unit. Tick and dispatch
// walk every slot, create walks up to the first free slot, delete, suspend
// and resume visit only the named slot, and unused commands skip the walk;
// a dispatch that grants a task ends with a state that marks it blocked.
// A full response register holds the sequencer until it drains. A new
// request is taken once the previous response is loaded, even if it has
// not yet been taken downstream. Task ids are slot + 1; id 0 names no task.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler_core #(
   parameter int MAX_TASKS    = pps_pkg::DEF_MAX_TASKS,
   parameter int MAX_PRIORITY = pps_pkg::DEF_MAX_PRIORITY
) (
   input  logic       clock,
   input  logic       reset,
   pps_req_if.sink    req_chan,
   pps_rsp_if.source  rsp_chan
);
   import pps_pkg::*;

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   logic                best_found_ff, best_found_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     granted_ff, granted_in;
   logic [CNT_W-1:0]    in_use_ff, in_use_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_granted_ff, rsp_granted_in;

   entry_type            rd_entry;
   entry_type            wr_entry;
   logic                 wr_en;
   logic [MAX_TASKS-1:0] valid_bits;
   unit_out_type         unit_out;
   logic                 last_slot;
   logic                 id_ok;
   logic                 due_slot;
   logic                 cand;
   logic                 take;
   logic                 load;

   pps_table #(
      .MAX_TASKS (MAX_TASKS),
      .IDX_W     (IDX_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_idx     (idx_ff),
      .rd_entry   (rd_entry),
      .wr_en      (wr_en),
      .wr_idx     (idx_ff),
      .wr_entry   (wr_entry),
      .valid_bits (valid_bits)
   );

   pps_unit u_unit (
      .count     (rd_entry.count),
      .period    (rd_entry.period),
      .prio      (rd_entry.prio),
      .best_prio (best_prio_ff),
      .result    (unit_out)
   );

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.granted_id = rsp_granted_ff;

   assign last_slot = (idx_ff == IDX_W'(MAX_TASKS - 1));
   assign id_ok     = (req_chan.task_id != '0) && (req_chan.task_id <= ID_W'(MAX_TASKS));
   assign due_slot  = rd_entry.valid && (rd_entry.mode != MODE_SUSPENDED) && unit_out.due;
   assign cand      = rd_entry.valid && (due_slot || (rd_entry.mode == MODE_READY));
   assign take      = cand && (!best_found_ff || unit_out.better);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      period_in     = period_ff;
      prio_in       = prio_ff;
      best_in       = best_ff;
      best_prio_in  = best_prio_ff;
      best_found_in = best_found_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      in_use_in     = in_use_ff;
      wr_en         = 1'b0;
      wr_entry      = rd_entry;
      load          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in        = req_chan.cmd;
               period_in     = req_chan.period;
               prio_in       = req_chan.priority_req;
               best_found_in = 1'b0;
               status_in     = ST_OK;
               granted_in    = '0;
               idx_in        = '0;
               state_in      = S_WALK;
               priority if (req_chan.cmd == CMD_CREATE) begin
                  if (in_use_ff >= CNT_W'(MAX_TASKS)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else if (req_chan.priority_req > PRIO_W'(MAX_PRIORITY)) begin
                     status_in = ST_BAD_PRIO;
                     state_in  = S_DONE;
                  end
               end else if (req_chan.cmd == CMD_DELETE || req_chan.cmd == CMD_SUSPEND ||
                            req_chan.cmd == CMD_RESUME) begin
                  if (id_ok) begin
                     idx_in = IDX_W'(req_chan.task_id - ID_W'(1));
                  end else begin
                     status_in = ST_NO_TASK;
                     state_in  = S_DONE;
                  end
               end else if (req_chan.cmd != CMD_TICK && req_chan.cmd != CMD_DISPATCH) begin
                  state_in = S_DONE;
               end
            end
         end

         S_WALK: begin
            idx_in = idx_ff + IDX_W'(1);
            unique case (cmd_ff)
               CMD_TICK: begin
                  if (rd_entry.valid && rd_entry.mode != MODE_SUSPENDED) begin
                     wr_en          = 1'b1;
                     wr_entry.count = unit_out.count_inc;
                  end
                  if (last_slot) state_in = S_DONE;
               end
               CMD_CREATE: begin
                  if (!rd_entry.valid) begin
                     wr_en           = 1'b1;
                     wr_entry.valid  = 1'b1;
                     wr_entry.mode   = MODE_READY;
                     wr_entry.count  = '0;
                     wr_entry.period = period_ff;
                     wr_entry.prio   = prio_ff;
                     in_use_in       = in_use_ff + CNT_W'(1);
                     status_in       = ST_CREATED;
                     granted_in      = ID_W'(idx_ff) + ID_W'(1);
                     state_in        = S_DONE;
                  end else if (last_slot) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end
               end
               CMD_DELETE, CMD_SUSPEND, CMD_RESUME: begin
                  state_in = S_DONE;
                  if (!rd_entry.valid) begin
                     status_in = ST_NO_TASK;
                  end else begin
                     wr_en = 1'b1;
                     if (cmd_ff == CMD_DELETE) begin
                        wr_entry.valid = 1'b0;
                        if (in_use_ff != '0) in_use_in = in_use_ff - CNT_W'(1);
                        status_in = ST_DELETED;
                     end else if (cmd_ff == CMD_SUSPEND) begin
                        wr_entry.mode = MODE_SUSPENDED;
                        status_in     = ST_SUSPENDED;
                     end else begin
                        wr_entry.mode  = MODE_BLOCKED;
                        wr_entry.count = '0;
                        status_in      = ST_RESUMED;
                     end
                  end
               end
               CMD_DISPATCH: begin
                  if (due_slot) begin
                     wr_en          = 1'b1;
                     wr_entry.mode  = MODE_READY;
                     wr_entry.count = '0;
                  end
                  if (take) begin
                     best_in       = idx_ff;
                     best_prio_in  = rd_entry.prio;
                     best_found_in = 1'b1;
                  end
                  if (last_slot) begin
                     if (take || best_found_ff) begin
                        idx_in   = take ? idx_ff : best_ff;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               end
               default: state_in = S_DONE;
            endcase
         end

         S_FIN: begin
            wr_en         = 1'b1;
            wr_entry.mode = MODE_BLOCKED;
            granted_in    = ID_W'(idx_ff) + ID_W'(1);
            state_in      = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_ff;
         rsp_granted_in = granted_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      cmd_ff         <= cmd_in;
      period_ff      <= period_in;
      prio_ff        <= prio_in;
      best_ff        <= best_in;
      best_prio_ff   <= best_prio_in;
      best_found_ff  <= best_found_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   // table occupancy count tracks the valid bits
   a_in_use_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_bits) == int'(in_use_ff))
      else $error("task count out of step with valid bits");

   a_in_use_bound: assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= CNT_W'(MAX_TASKS))
      else $error("task count above table size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while busy");

   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_granted_ff != '0) |->
         (rsp_status_ff == ST_CREATED || rsp_status_ff == ST_OK))
      else $error("granted id with error status");

   a_single_write_walk: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_WALK || state_ff == S_FIN))
      else $error("table write outside walk");

endmodule

// File: tb/sv/pps_task_table_mirror.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_task_table_mirror: task table predictor of the scheduler testbench
// Keeps its own copy of the task table, works out the response of each
// accepted request, and checks the responses in order against them.
// ----------------------------------------------------------------------------
package pps_mirror_pkg;
   import pps_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     granted_id;
   } outcome_type;

   class task_table_mirror;
      bit                live   [DEF_MAX_TASKS];
      logic [MODE_W-1:0] mode   [DEF_MAX_TASKS];
      bit [PERIOD_W-1:0] count  [DEF_MAX_TASKS];
      bit [PERIOD_W-1:0] period [DEF_MAX_TASKS];
      bit [PRIO_W-1:0]   prio   [DEF_MAX_TASKS];
      int                in_use;
      outcome_type       awaited[$];
      int                failures;

      function new();
         foreach (live[i]) begin
            live[i]   = 1'b0;
            mode[i]   = MODE_READY;
            count[i]  = '0;
            period[i] = '0;
            prio[i]   = '0;
         end
         in_use   = 0;
         failures = 0;
      endfunction

      function int slot_of(logic [ID_W-1:0] id);
         if (id == 0 || id > DEF_MAX_TASKS) return -1;
         if (!live[id - 1]) return -1;
         return int'(id) - 1;
      endfunction

      function void apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                  logic [PERIOD_W-1:0] per, logic [PRIO_W-1:0] pr);
         outcome_type o;
         int          s;
         int          best;
         int          i;
         o.status     = ST_OK;
         o.granted_id = '0;
         case (cmd)
            CMD_TICK: begin
               for (i = 0; i < DEF_MAX_TASKS; i++)
                  if (live[i] && mode[i] != MODE_SUSPENDED && count[i] != '1)
                     count[i] = count[i] + 1;
            end
            CMD_CREATE: begin
               if (in_use >= DEF_MAX_TASKS) begin
                  o.status = ST_FULL;
               end else if (pr > DEF_MAX_PRIORITY) begin
                  o.status = ST_BAD_PRIO;
               end else begin
                  o.status = ST_FULL;
                  for (i = 0; i < DEF_MAX_TASKS; i++) begin
                     if (!live[i]) begin
                        live[i]      = 1'b1;
                        mode[i]      = MODE_READY;
                        count[i]     = '0;
                        period[i]    = per;
                        prio[i]      = pr;
                        in_use++;
                        o.status     = ST_CREATED;
                        o.granted_id = ID_W'(i + 1);
                        break;
                     end
                  end
               end
            end
            CMD_DELETE: begin
               s = slot_of(id);
               if (s < 0) begin
                  o.status = ST_NO_TASK;
               end else begin
                  live[s] = 1'b0;
                  if (in_use > 0) in_use--;
                  o.status = ST_DELETED;
               end
            end
            CMD_SUSPEND: begin
               s = slot_of(id);
               if (s < 0) begin
                  o.status = ST_NO_TASK;
               end else begin
                  mode[s]  = MODE_SUSPENDED;
                  o.status = ST_SUSPENDED;
               end
            end
            CMD_RESUME: begin
               s = slot_of(id);
               if (s < 0) begin
                  o.status = ST_NO_TASK;
               end else begin
                  mode[s]  = MODE_BLOCKED;
                  count[s] = '0;
                  o.status = ST_RESUMED;
               end
            end
            CMD_DISPATCH: begin
               best = -1;
               for (i = 0; i < DEF_MAX_TASKS; i++) begin
                  if (live[i] && mode[i] != MODE_SUSPENDED && count[i] >= period[i]) begin
                     mode[i]  = MODE_READY;
                     count[i] = '0;
                  end
               end
               for (i = 0; i < DEF_MAX_TASKS; i++)
                  if (live[i] && mode[i] == MODE_READY && (best < 0 || prio[i] < prio[best]))
                     best = i;
               if (best >= 0) begin
                  mode[best]   = MODE_BLOCKED;
                  o.granted_id = ID_W'(best + 1);
               end
            end
            default: begin
            end
         endcase
         awaited.push_back(o);
      endfunction

      function void compare_response(logic [STATUS_W-1:0] status,
                                     logic [ID_W-1:0] granted_id);
         outcome_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response with no request pending: status=%0d granted_id=%0d",
                     $time, status, granted_id);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            failures++;
         end
         if (granted_id !== want.granted_id) begin
            $display("%0t: granted_id expected %0d actual %0d",
                     $time, want.granted_id, granted_id);
            failures++;
         end
      endfunction
   endclass
endpackage

// File: tb/sv/periodic_priority_task_scheduler_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler_core_test: scheduler core testbench
// Directed table commands, then weighted random command streams with bursty
// requests and a stalling response side; every response is checked against
// a task table predictor.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler_core_test;
   import pps_pkg::*;
   import pps_mirror_pkg::*;

   localparam int CLOCK_HIGH      = 6;
   localparam int CLOCK_LOW       = 6;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_REQUESTS = 850;
   localparam int DRAIN_CYCLES    = 2 * (DEF_MAX_TASKS + 3);

   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_MASK, FLOW_CHOKE} flow_kind_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   int            cycle_count = 0;
   int            burst_left = 0;
   flow_kind_type stall_mode = FLOW_FREE;
   logic [7:0]    stall_mask = 8'hff;

   task_table_mirror table_mirror;

   pps_req_if req_chan ();
   pps_rsp_if rsp_chan ();

   periodic_priority_task_scheduler_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #(CLOCK_LOW) clock = 1'b1;
      #(CLOCK_HIGH) clock = 1'b0;
   end

   // response side back-pressure, with a pattern that changes periodically
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) begin
         stall_mode <= flow_kind_type'($urandom_range(0, 3));
         stall_mask <= 8'($urandom_range(1, 255));
      end
      case (stall_mode)
         FLOW_FREE: rsp_chan.ready <= 1'b1;
         FLOW_COIN: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         FLOW_MASK: rsp_chan.ready <= stall_mask[cycle_count % 8];
         default:   rsp_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         table_mirror.compare_response(rsp_chan.status, rsp_chan.granted_id);
   end

   task automatic send_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [PERIOD_W-1:0] per, logic [PRIO_W-1:0] pr);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= cmd;
      req_chan.task_id      <= id;
      req_chan.period       <= per;
      req_chan.priority_req <= pr;
      do @(negedge clock); while (req_chan.ready !== 1'b1);
      @(posedge clock);
      table_mirror.apply_command(cmd, id, per, pr);
   endtask

   initial begin
      logic [CMD_W-1:0]    cmd;
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] per;
      logic [PRIO_W-1:0]   pr;
      int                  pick;
      int                  issued;

      req_chan.valid        = 1'b0;
      req_chan.cmd          = CMD_TICK;
      req_chan.task_id      = '0;
      req_chan.period       = '0;
      req_chan.priority_req = '0;
      rsp_chan.ready        = 1'b0;
      table_mirror          = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table, ids naming nothing, bad priorities
      send_request(CMD_DISPATCH, '0, '0, '0);
      send_request(CMD_TICK, '0, '0, '0);
      send_request(CMD_DELETE, '0, '0, '0);
      send_request(CMD_SUSPEND, 6'd1, '0, '0);
      send_request(CMD_RESUME, '1, '0, '0);
      send_request(CMD_CREATE, '0, 32'd3, 8'(DEF_MAX_PRIORITY + 1));
      send_request(CMD_CREATE, '0, 32'd3, '1);
      // priority at the limit, period zero and all ones
      send_request(CMD_CREATE, '0, '0, 8'(DEF_MAX_PRIORITY));
      send_request(CMD_CREATE, '0, '1, '0);
      send_request(CMD_CREATE, '0, 32'd2, 8'(DEF_MAX_PRIORITY));
      send_request(CMD_DISPATCH, '0, '0, '0);
      send_request(CMD_DISPATCH, '0, '0, '0);
      send_request(CMD_TICK, '0, '0, '0);
      send_request(CMD_SUSPEND, 6'd1, '0, '0);
      send_request(CMD_RESUME, 6'd2, '0, '0);
      send_request(CMD_RESUME, 6'd1, '0, '0);
      send_request(CMD_DISPATCH, '0, '0, '0);
      // fill the table; full wins over a bad priority
      repeat (DEF_MAX_TASKS - 3)
         send_request(CMD_CREATE, '0, 32'($urandom_range(1, 4)),
                      8'($urandom_range(1, DEF_MAX_PRIORITY - 1)));
      send_request(CMD_CREATE, '0, 32'd1, 8'd200);
      send_request(CMD_SPARE_LO, '1, '1, '1);
      send_request(CMD_SPARE_HI, '0, '0, '0);
      send_request(CMD_DELETE, 6'(DEF_MAX_TASKS), '0, '0);
      send_request(CMD_DELETE, 6'(DEF_MAX_TASKS + 1), '0, '0);

      issued = 0;
      while (issued < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         id   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(1, DEF_MAX_TASKS));
         pr   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, DEF_MAX_PRIORITY));
         per  = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6));
         if (pick < 30)      cmd = CMD_TICK;
         else if (pick < 55) cmd = CMD_DISPATCH;
         else if (pick < 67) cmd = CMD_CREATE;
         else if (pick < 77) cmd = CMD_DELETE;
         else if (pick < 86) cmd = CMD_SUSPEND;
         else if (pick < 95) cmd = CMD_RESUME;
         else                cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
         send_request(cmd, id, per, pr);
         if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) issued++;
      end

      req_chan.valid <= 1'b0;
      while (table_mirror.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_mirror.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// File: files.f
src/pps_pkg.sv
src/pps_if.sv
src/pps_unit.sv
src/pps_table.sv
src/periodic_priority_task_scheduler_core.sv
tb/sv/pps_task_table_mirror.sv
tb/sv/periodic_priority_task_scheduler_core_test.sv
